// ----- rtl/allh_pkg.sv -----
// ----------------------------------------------------------------------------
// allh_pkg
// Shared types and constants for the automatic light level controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package allh_pkg;

    // illumination transfer constants (q8.8 result)
    localparam int FULL_SCALE   = 8191;
    localparam int LIGHT_GAIN   = 3644;
    localparam int LIGHT_OFFSET = 2560;
    localparam int GAIN_BITS    = 13;
    localparam int GAIN_SHIFT   = 10;

    // register map
    localparam int          PADDR_W   = 4;
    localparam int          PDATA_W   = 32;
    localparam int          THRESH_W  = 7;
    localparam int          HYST_W    = 4;
    localparam logic [1:0]  REG_MIN   = 2'd0;
    localparam logic [1:0]  REG_MID   = 2'd1;
    localparam logic [1:0]  REG_MAX   = 2'd2;
    localparam logic [1:0]  REG_HYST  = 2'd3;

    // reset values of the registers
    localparam logic [THRESH_W-1:0] MIN_RESET  = 7'd20;
    localparam logic [THRESH_W-1:0] MID_RESET  = 7'd45;
    localparam logic [THRESH_W-1:0] MAX_RESET  = 7'd70;
    localparam logic [HYST_W-1:0]   HYST_RESET = 4'd2;

    // brightness levels; lamp command is the bitwise inverse
    typedef enum logic [1:0] {
        LEVEL_NONE = 2'd0,
        LEVEL_MIN  = 2'd1,
        LEVEL_MID  = 2'd2,
        LEVEL_MAX  = 2'd3
    } level_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [THRESH_W-1:0] min_threshold;
        logic [THRESH_W-1:0] mid_threshold;
        logic [THRESH_W-1:0] max_threshold;
        logic [HYST_W-1:0]   hysteresis;
    } cfg_t;

endpackage

// ----- rtl/allh_regs.sv -----
// ----------------------------------------------------------------------------
// allh_regs
// APB register file holding thresholds and hysteresis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module allh_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [allh_pkg::PADDR_W-1:0]  paddr,
    input  logic [allh_pkg::PDATA_W-1:0]  pwdata,
    output logic [allh_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output allh_pkg::cfg_t                cfg
);
    import allh_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.min_threshold <= MIN_RESET;
            cfg_reg.mid_threshold <= MID_RESET;
            cfg_reg.max_threshold <= MAX_RESET;
            cfg_reg.hysteresis    <= HYST_RESET;
        end
        else if (wr_en) begin
            case (reg_idx)
                REG_MIN:  cfg_reg.min_threshold <= pwdata[THRESH_W-1:0];
                REG_MID:  cfg_reg.mid_threshold <= pwdata[THRESH_W-1:0];
                REG_MAX:  cfg_reg.max_threshold <= pwdata[THRESH_W-1:0];
                REG_HYST: cfg_reg.hysteresis    <= pwdata[HYST_W-1:0];
                default:  ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_MIN:  prdata = PDATA_W'(cfg_reg.min_threshold);
            REG_MID:  prdata = PDATA_W'(cfg_reg.mid_threshold);
            REG_MAX:  prdata = PDATA_W'(cfg_reg.max_threshold);
            REG_HYST: prdata = PDATA_W'(cfg_reg.hysteresis);
            default:  prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/allh_illum.sv -----
// ----------------------------------------------------------------------------
// allh_illum
// Sums four sensor samples and maps them to signed q8.8 illumination.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module allh_illum #(
    parameter int SAMPLE_BITS = 12,
    parameter int ILLUM_W     = 18
) (
    input  logic [SAMPLE_BITS-1:0]    sample_a,
    input  logic [SAMPLE_BITS-1:0]    sample_b,
    input  logic [SAMPLE_BITS-1:0]    sample_c,
    input  logic [SAMPLE_BITS-1:0]    sample_d,
    output logic signed [ILLUM_W-1:0] illum
);
    import allh_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int DIFF_W = (SAMPLE_BITS + 2 > 14) ? SAMPLE_BITS + 2 : 14;
    localparam int PROD_W = DIFF_W + GAIN_BITS;

    logic [SUM_W-1:0]         sum;
    logic [SUM_W-2:0]         half;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] diff_ext;
    logic signed [PROD_W-1:0] gain_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] scaled;

    // sum and halve
    assign sum  = SUM_W'(sample_a) + SUM_W'(sample_b) + SUM_W'(sample_c)
                + SUM_W'(sample_d);
    assign half = sum[SUM_W-1:1];

    // distance from full scale, signed
    assign diff = DIFF_W'(FULL_SCALE) - DIFF_W'(half);

    // constant gain, arithmetic shift floors toward minus infinity
    assign diff_ext = {{GAIN_BITS{diff[DIFF_W-1]}}, diff};
    assign gain_ext = PROD_W'(LIGHT_GAIN);
    assign prod     = diff_ext * gain_ext;
    assign scaled   = prod >>> GAIN_SHIFT;

    assign illum = scaled[ILLUM_W-1:0] - ILLUM_W'(LIGHT_OFFSET);

endmodule

// ----- rtl/allh_level.sv -----
// ----------------------------------------------------------------------------
// allh_level
// Hysteresis level tracker with the result register and output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module allh_level #(
    parameter int ILLUM_W = 18
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  allh_pkg::cfg_t            cfg,
    input  logic                      item_valid,
    input  logic                      item_auto,
    input  logic signed [ILLUM_W-1:0] illum,
    output logic                      item_take,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                light_command
);
    import allh_pkg::*;

    level_t                    level_reg;
    level_t                    level_next;
    level_t                    auto_next;
    logic                      out_valid_reg;
    logic [1:0]                cmd_reg;
    logic                      changed;
    logic                      out_free;
    logic signed [ILLUM_W-1:0] t_min;
    logic signed [ILLUM_W-1:0] t_mid;
    logic signed [ILLUM_W-1:0] t_max;
    logic signed [ILLUM_W-1:0] hyst;

    // thresholds scaled to q8.8
    assign t_min = ILLUM_W'({cfg.min_threshold, 8'd0});
    assign t_mid = ILLUM_W'({cfg.mid_threshold, 8'd0});
    assign t_max = ILLUM_W'({cfg.max_threshold, 8'd0});
    assign hyst  = ILLUM_W'({cfg.hysteresis, 8'd0});

    // cascade: step down at once, step up only past threshold plus margin
    always_comb begin
        auto_next = level_reg;
        if (illum > t_max) begin
            if (level_reg != LEVEL_MAX && illum > t_max + hyst)
                auto_next = LEVEL_MAX;
        end
        else if (illum > t_mid) begin
            if (level_reg == LEVEL_MAX)
                auto_next = LEVEL_MID;
            else if (level_reg != LEVEL_MID && illum > t_mid + hyst)
                auto_next = LEVEL_MID;
        end
        else if (illum > t_min) begin
            if (level_reg == LEVEL_MAX || level_reg == LEVEL_MID)
                auto_next = LEVEL_MIN;
            else if (level_reg == LEVEL_NONE && illum > t_min + hyst)
                auto_next = LEVEL_MIN;
        end
        else begin
            auto_next = LEVEL_NONE;
        end
    end

    // manual mode pins the level at max and stays silent
    assign level_next = item_auto ? auto_next : LEVEL_MAX;
    assign changed    = item_auto && (auto_next != level_reg);

    // an item without a result never waits for the output side
    assign out_free  = !out_valid_reg || !out_stall;
    assign item_take = item_valid && (!changed || out_free);

    // level state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            level_reg <= LEVEL_MAX;
        else if (item_take)
            level_reg <= level_next;
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item_take && changed)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result beat payload
    always_ff @(posedge clk) begin
        if (item_take && changed)
            cmd_reg <= ~auto_next;
    end

    assign out_valid     = out_valid_reg;
    assign light_command = cmd_reg;

endmodule

// ----- rtl/auto_light_level_hysteresis.sv -----
// ----------------------------------------------------------------------------
// auto_light_level_hysteresis
// A result beat is presented in the cycle after the level tracker takes its beat from the input register.
// Throughput: one input beat per cycle; only a held result beat whose slot is
// needed by a level change stalls the input register.
// Reset: level at max, thresholds 20/45/70, hysteresis 2, no beat pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module auto_light_level_hysteresis #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [allh_pkg::PADDR_W-1:0]  paddr,
    input  logic [allh_pkg::PDATA_W-1:0]  pwdata,
    output logic [allh_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_BITS-1:0]        sample_a,
    input  logic [SAMPLE_BITS-1:0]        sample_b,
    input  logic [SAMPLE_BITS-1:0]        sample_c,
    input  logic [SAMPLE_BITS-1:0]        sample_d,
    input  logic                          auto_enable,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    light_command
);
    import allh_pkg::*;

    localparam int DIFF_W  = (SAMPLE_BITS + 2 > 14) ? SAMPLE_BITS + 2 : 14;
    localparam int ILLUM_W = DIFF_W + GAIN_BITS - GAIN_SHIFT + 1;

    cfg_t                      cfg;
    logic                      in_valid_reg;
    logic [SAMPLE_BITS-1:0]    sample_a_reg;
    logic [SAMPLE_BITS-1:0]    sample_b_reg;
    logic [SAMPLE_BITS-1:0]    sample_c_reg;
    logic [SAMPLE_BITS-1:0]    sample_d_reg;
    logic                      auto_reg;
    logic                      item_take;
    logic signed [ILLUM_W-1:0] illum;

    // configuration registers
    allh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register stalls only while its beat cannot move on
    assign in_stall = in_valid_reg && !item_take;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk) begin
        if (in_valid && !in_stall) begin
            sample_a_reg <= sample_a;
            sample_b_reg <= sample_b;
            sample_c_reg <= sample_c;
            sample_d_reg <= sample_d;
            auto_reg     <= auto_enable;
        end
    end

    // illumination from the registered samples
    allh_illum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ILLUM_W     (ILLUM_W)
    ) u_illum (
        .sample_a (sample_a_reg),
        .sample_b (sample_b_reg),
        .sample_c (sample_c_reg),
        .sample_d (sample_d_reg),
        .illum    (illum)
    );

    // level update and result register
    allh_level #(
        .ILLUM_W (ILLUM_W)
    ) u_level (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item_valid    (in_valid_reg),
        .item_auto     (auto_reg),
        .illum         (illum),
        .item_take     (item_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .light_command (light_command)
    );

endmodule

// ----- tb/light_command_checker.sv -----
// ----------------------------------------------------------------------------
// light_command_checker
// Watches the register port and both beat channels of the light level
// controller, predicts the lamp command for each accepted sample group that
// changes the level and compares each accepted command beat to the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module light_command_checker #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [allh_pkg::PADDR_W-1:0]  paddr,
    input  logic [allh_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [SAMPLE_BITS-1:0]        sample_a,
    input  logic [SAMPLE_BITS-1:0]        sample_b,
    input  logic [SAMPLE_BITS-1:0]        sample_c,
    input  logic [SAMPLE_BITS-1:0]        sample_d,
    input  logic                          auto_enable,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    light_command,
    output int                            fail_count,
    output int                            pending
);

    import allh_pkg::*;

    cfg_t       cfg;
    level_t     level;
    logic [1:0] cmd_queue [$];

    // q8.8 illumination from the four samples, floor division by 1024
    function automatic int illumination_q88(input int sa, input int sb,
                                            input int sc, input int sd);
        int sum;
        int diff;
        int prod;
        int quot;
        sum  = sa + sb + sc + sd;
        diff = FULL_SCALE - (sum >>> 1);
        prod = diff * LIGHT_GAIN;
        if (prod >= 0)
            quot = prod / (1 << GAIN_SHIFT);
        else
            quot = -((-prod + (1 << GAIN_SHIFT) - 1) / (1 << GAIN_SHIFT));
        return quot - LIGHT_OFFSET;
    endfunction

    // threshold cascade: down steps at once, up steps need the margin
    function automatic level_t next_level(input level_t cur, input int lux);
        int     margin;
        int     t_max;
        int     t_mid;
        int     t_min;
        level_t nxt;
        margin = int'(cfg.hysteresis) << 8;
        t_max  = int'(cfg.max_threshold) << 8;
        t_mid  = int'(cfg.mid_threshold) << 8;
        t_min  = int'(cfg.min_threshold) << 8;
        nxt    = cur;
        if (lux > t_max)
        begin
            if (cur != LEVEL_MAX && lux > t_max + margin)
                nxt = LEVEL_MAX;
        end
        else if (lux > t_mid)
        begin
            if (cur == LEVEL_MAX)
                nxt = LEVEL_MID;
            else if (cur < LEVEL_MID && lux > t_mid + margin)
                nxt = LEVEL_MID;
        end
        else if (lux > t_min)
        begin
            if (cur > LEVEL_MIN)
                nxt = LEVEL_MIN;
            else if (cur == LEVEL_NONE && lux > t_min + margin)
                nxt = LEVEL_MIN;
        end
        else
        begin
            nxt = LEVEL_NONE;
        end
        return nxt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        int         lux;
        level_t     nxt;
        logic [1:0] want;
        if (!rst_n)
        begin
            cfg.min_threshold = MIN_RESET;
            cfg.mid_threshold = MID_RESET;
            cfg.max_threshold = MAX_RESET;
            cfg.hysteresis    = HYST_RESET;
            level             = LEVEL_MAX;
            cmd_queue.delete();
            pending           = 0;
            fail_count        = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_MIN:  cfg.min_threshold = pwdata[THRESH_W-1:0];
                    REG_MID:  cfg.mid_threshold = pwdata[THRESH_W-1:0];
                    REG_MAX:  cfg.max_threshold = pwdata[THRESH_W-1:0];
                    REG_HYST: cfg.hysteresis    = pwdata[HYST_W-1:0];
                    default:  ;
                endcase
            end

            // command beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (cmd_queue.size() == 0)
                begin
                    $error("light_command beat with nothing expected: got %0d",
                           light_command);
                    fail_count++;
                end
                else
                begin
                    want = cmd_queue.pop_front();
                    if (light_command !== want)
                    begin
                        $error("light_command mismatch: expected %0d, got %0d",
                               want, light_command);
                        fail_count++;
                    end
                end
            end

            // sample group beat: auto off forces max silently
            if (in_valid && !in_stall)
            begin
                if (!auto_enable)
                begin
                    level = LEVEL_MAX;
                end
                else
                begin
                    lux = illumination_q88(int'(sample_a), int'(sample_b),
                                           int'(sample_c), int'(sample_d));
                    nxt = next_level(level, lux);
                    if (nxt != level)
                    begin
                        level = nxt;
                        cmd_queue.push_back(~nxt);
                    end
                end
            end
            pending = cmd_queue.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the automatic light level controller: register settings over
// the apb port, directed sample groups around every threshold and margin,
// then random groups mostly aimed at the thresholds, with random idling
// on both channels. Prediction and checking sit in light_command_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import allh_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 150;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 55;
    localparam int MAX_SAMPLE     = 4095;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [11:0]          sample_a    = '0;
    logic [11:0]          sample_b    = '0;
    logic [11:0]          sample_c    = '0;
    logic [11:0]          sample_d    = '0;
    logic                 auto_enable = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [1:0]           light_command;

    int  chk_fails;
    int  chk_pending;
    int  cycle_count = 0;
    bit  quiet       = 1'b0;
    bit  hold_req    = 1'b0;

    // settings last written, used to aim stimulus at the thresholds
    int  thr_min;
    int  thr_mid;
    int  thr_max;
    int  thr_hyst;

    auto_light_level_hysteresis u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .sample_c      (sample_c),
        .sample_d      (sample_d),
        .auto_enable   (auto_enable),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .light_command (light_command)
    );

    light_command_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .sample_c      (sample_c),
        .sample_d      (sample_d),
        .auto_enable   (auto_enable),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .light_command (light_command),
        .fail_count    (chk_fails),
        .pending       (chk_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // command receiver: random stalls, one long hold on request
    initial
    begin : receiver
        int len;
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (quiet || $urandom_range(0, 3) != 0)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
        end
    end

    // sender idle length before a beat
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic reg_write(input logic [1:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(input int mn, input int md, input int mx,
                                 input int hy);
        reg_write(REG_MIN, mn);
        reg_write(REG_MID, md);
        reg_write(REG_MAX, mx);
        reg_write(REG_HYST, hy);
        thr_min  = mn;
        thr_mid  = md;
        thr_max  = mx;
        thr_hyst = hy;
    endtask

    task automatic send_item(input logic [11:0] a, input logic [11:0] b,
                             input logic [11:0] c, input logic [11:0] d,
                             input logic en);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_a    <= a;
        sample_b    <= b;
        sample_c    <= c;
        sample_d    <= d;
        auto_enable <= en;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // sample group whose illumination is the smallest reachable one >= target
    task automatic send_illum(input int target, input logic en);
        int         num;
        int         diff;
        int         sum;
        int         rem;
        int         lo;
        int         hi;
        logic [11:0] s [4];
        num = (target + LIGHT_OFFSET) * (1 << GAIN_SHIFT);
        if (num <= 0)
            diff = 1;
        else
            diff = (num + LIGHT_GAIN - 1) / LIGHT_GAIN;
        if (diff < 1)
            diff = 1;
        if (diff > FULL_SCALE)
            diff = FULL_SCALE;
        sum = 2 * (FULL_SCALE - diff) + $urandom_range(0, 1);
        if (sum > 4 * MAX_SAMPLE)
            sum = 4 * MAX_SAMPLE;
        rem = sum;
        for (int k = 0; k < 4; k++)
        begin
            lo = rem - (3 - k) * MAX_SAMPLE;
            if (lo < 0)
                lo = 0;
            hi = (rem > MAX_SAMPLE) ? MAX_SAMPLE : rem;
            s[k] = 12'($urandom_range(lo, hi));
            rem -= s[k];
        end
        send_item(s[0], s[1], s[2], s[3], en);
    endtask

    // wait until every predicted command has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int r;
        int t;
        int target;
        int mn;
        int md;
        int mx;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        thr_min  = MIN_RESET;
        thr_mid  = MID_RESET;
        thr_max  = MAX_RESET;
        thr_hyst = HYST_RESET;

        // directed: extremes, each band, margins, auto off
        send_item(12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        send_item(12'hfff, 12'hfff, 12'hfff, 12'hfff, 1'b1);
        send_illum((thr_min << 8) + (thr_hyst << 7), 1'b1);
        send_illum(((thr_min + thr_hyst) << 8) + 1, 1'b1);
        send_illum((thr_mid << 8) + 1, 1'b1);
        send_illum(((thr_mid + thr_hyst) << 8) + 1, 1'b1);
        send_illum((thr_max + thr_hyst) << 8, 1'b1);
        send_illum(((thr_max + thr_hyst) << 8) + 1, 1'b1);
        send_illum((thr_mid << 8) + 1, 1'b1);
        send_illum((thr_min << 8) + 1, 1'b1);
        send_illum(thr_min << 8, 1'b1);
        send_illum(((thr_max + thr_hyst) << 8) + 1, 1'b1);
        send_illum(0, 1'b1);
        send_item(12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        send_item(12'hfff, 12'hfff, 12'hfff, 12'hfff, 1'b0);
        send_item(12'hfff, 12'hfff, 12'hfff, 12'hfff, 1'b1);
        send_item(12'hfff, 12'd0, 12'd0, 12'd0, 1'b1);
        send_item(12'd0, 12'hfff, 12'd0, 12'd0, 1'b1);
        send_item(12'd0, 12'd0, 12'hfff, 12'd0, 1'b1);
        send_item(12'd0, 12'd0, 12'd0, 12'hfff, 1'b1);
        send_illum(-LIGHT_OFFSET, 1'b1);
        send_item(12'hfff, 12'hfff, 12'hfff, 12'hfff, 1'b0);
        send_illum(((thr_mid + thr_hyst) << 8) + 1, 1'b1);

        // long receiver hold while bright and dark groups keep coming
        quiet    = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 2 == 0)
                send_item(12'hfff, 12'hfff, 12'hfff, 12'hfff, 1'b1);
            else
                send_item(12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        end
        quiet = 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            // new settings only with the block drained
            settle();
            case (p)
                0: ;
                1: load_settings(0, 0, 0, 0);
                2: load_settings(127, 127, 127, 15);
                3: load_settings(90, 50, 10, 7);
                4: load_settings(10, 30, 60, 15);
                5:
                begin
                    mn = $urandom_range(0, 60);
                    md = mn + $urandom_range(0, 30);
                    mx = md + $urandom_range(0, 30);
                    load_settings(mn, md, mx, $urandom_range(0, 15));
                end
                default:
                    load_settings($urandom_range(0, 127), $urandom_range(0, 127),
                                  $urandom_range(0, 127), $urandom_range(0, 15));
            endcase

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 10 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    case ($urandom_range(0, 2))
                        0:       t = thr_min;
                        1:       t = thr_mid;
                        default: t = thr_max;
                    endcase
                    target = (t << 8) - 768 + $urandom_range(0, (thr_hyst + 6) * 256);
                    send_illum(target, $urandom_range(0, 19) != 0);
                end
                else
                begin
                    send_item(12'($urandom_range(0, MAX_SAMPLE)),
                              12'($urandom_range(0, MAX_SAMPLE)),
                              12'($urandom_range(0, MAX_SAMPLE)),
                              12'($urandom_range(0, MAX_SAMPLE)),
                              (r < 92) ? 1'b1 : 1'($urandom_range(0, 1)));
                end
            end
            quiet = 1'b0;
        end

        settle();
        if (chk_fails == 0 && chk_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
